>>> rtl/sorted_table_search_insert_remove_top_macros.svh
// Assertion macros for the sorted key table.
`ifndef SORTED_TABLE_SEARCH_INSERT_REMOVE_TOP_MACROS_SVH
`define SORTED_TABLE_SEARCH_INSERT_REMOVE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STSIR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STSIR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/stsir_pkg.sv
// Package with the constants, codes and state type of the sorted key table.
`default_nettype none
package stsir_pkg;
	localparam int DEPTH = 256;
	localparam int KEY_W = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] OP_FIND   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHUP_RD,
		S_SHUP_WR,
		S_SHDN_RD,
		S_SHDN_WR,
		S_INS_WR
	} stsir_state_t;
endpackage
`default_nettype wire

>>> rtl/sorted_table_search_insert_remove_top.sv
// Top level of the sorted key table with find, insert and remove commands.
// A command is taken when start is high and busy is low, and exactly one result
// word follows, shown for one cycle with done high; the receiver cannot stall it.
// All keys sit in one memory with a registered read, and every search or shift step
// reads that memory once, so the time per command depends on the table contents.
// A find runs binary search steps until a hit or a miss. An insert runs its search,
// moves every entry above the insert point up by one and then writes the key; a
// remove runs its search and moves every entry above the hit down by one. A full
// insert or an unknown opcode is answered from idle without a search. No clearing
// pass follows reset: the table starts empty at once.
`default_nettype none
`include "sorted_table_search_insert_remove_top_macros.svh"
module sorted_table_search_insert_remove_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [1:0]                opcode,
	input  wire logic [stsir_pkg::KEY_W-1:0] key,
	input  wire logic                      batch_last,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [stsir_pkg::CNT_W-1:0]    position,
	output logic [stsir_pkg::CNT_W-1:0]    entries,
	output logic                           result_last
);
	import stsir_pkg::*;

	stsir_state_t        state_q, state_d;
	logic [1:0]          op_q;
	logic [KEY_W-1:0]    key_q;
	logic                last_q;
	logic [CNT_W-1:0]    lo_q, lo_d, hi_q, hi_d;
	logic [CNT_W-1:0]    ptr_q, ptr_d, pos_q, pos_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic                done_q, done_d;
	logic [1:0]          status_q, status_d;
	logic [CNT_W:0]      mid_sum;
	logic [CNT_W-1:0]    mid;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr, mem_raddr;
	logic [KEY_W-1:0]    mem_wdata, mem_rdata;
	logic                key_eq, key_lt;

	stsir_ram #(
		.DEPTH_P(DEPTH),
		.WIDTH_P(KEY_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CNT_W + 1)'(1);
	assign mid     = mid_sum[CNT_W:1];
	assign key_eq  = key_q == mem_rdata;
	assign key_lt  = $signed(key_q) < $signed(mem_rdata);

	always_comb begin
		state_d   = state_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		ptr_d     = ptr_q;
		pos_d     = pos_q;
		count_d   = count_q;
		done_d    = 1'b0;
		status_d  = status_q;
		mem_we    = 1'b0;
		mem_waddr = ptr_q[IDX_W-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = mid[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					lo_d = '0;
					hi_d = count_q;
					pos_d = '0;
					priority if (opcode == OP_FIND || opcode == OP_REMOVE) begin
						state_d = S_SRCH_RD;
					end else if (opcode == OP_INSERT) begin
						if (count_q == CNT_W'(DEPTH)) begin
							done_d = 1'b1;
							status_d = ST_FULL;
						end else begin
							state_d = S_SRCH_RD;
						end
					end else begin
						done_d = 1'b1;
						status_d = ST_MISSING;
					end
				end
			end
			S_SRCH_RD: begin
				if (lo_q < hi_q) begin
					state_d = S_SRCH_CMP;
				end else if (op_q == OP_INSERT) begin
					pos_d = lo_q;
					ptr_d = count_q;
					state_d = (count_q > lo_q) ? S_SHUP_RD : S_INS_WR;
				end else begin
					done_d = 1'b1;
					status_d = ST_MISSING;
					pos_d = '0;
					state_d = S_IDLE;
				end
			end
			S_SRCH_CMP: begin
				if (op_q != OP_INSERT && key_eq) begin
					pos_d = mid;
					ptr_d = mid;
					if (op_q == OP_REMOVE && mid + CNT_W'(1) < count_q) begin
						state_d = S_SHDN_RD;
					end else begin
						if (op_q == OP_REMOVE) begin
							count_d = count_q - CNT_W'(1);
						end
						done_d = 1'b1;
						status_d = ST_DONE;
						state_d = S_IDLE;
					end
				end else begin
					if (key_lt) begin
						hi_d = mid;
					end else begin
						lo_d = mid + CNT_W'(1);
					end
					state_d = S_SRCH_RD;
				end
			end
			S_SHUP_RD: begin
				mem_raddr = IDX_W'(ptr_q - CNT_W'(1));
				state_d = S_SHUP_WR;
			end
			S_SHUP_WR: begin
				mem_we = 1'b1;
				ptr_d = ptr_q - CNT_W'(1);
				state_d = (ptr_q - CNT_W'(1) != pos_q) ? S_SHUP_RD : S_INS_WR;
			end
			S_INS_WR: begin
				mem_we = 1'b1;
				mem_waddr = pos_q[IDX_W-1:0];
				mem_wdata = key_q;
				count_d = count_q + CNT_W'(1);
				done_d = 1'b1;
				status_d = ST_DONE;
				state_d = S_IDLE;
			end
			S_SHDN_RD: begin
				mem_raddr = IDX_W'(ptr_q + CNT_W'(1));
				state_d = S_SHDN_WR;
			end
			S_SHDN_WR: begin
				mem_we = 1'b1;
				ptr_d = ptr_q + CNT_W'(1);
				if ((CNT_W + 1)'(ptr_q) + (CNT_W + 1)'(2) < (CNT_W + 1)'(count_q)) begin
					state_d = S_SHDN_RD;
				end else begin
					count_d = count_q - CNT_W'(1);
					done_d = 1'b1;
					status_d = ST_DONE;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q   <= opcode;
			key_q  <= key;
			last_q <= batch_last;
		end
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		ptr_q    <= ptr_d;
		pos_q    <= pos_d;
		status_q <= status_d;
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign position    = pos_q;
	assign entries     = count_q;
	assign result_last = last_q;

	`STSIR_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`STSIR_ASSERT_NEXT(a_done_after_work, busy && state_d == S_IDLE, done_q, "command ended without a word")
	`STSIR_ASSERT_NOW(a_full_count, done_q && status_q == ST_FULL, count_q == CNT_W'(DEPTH), "full status below depth")
	`STSIR_ASSERT_NOW(a_done_idle, done_q, state_q == S_IDLE, "result shown while still working")
endmodule
`default_nettype wire

>>> rtl/stsir_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module stsir_ram #(
	parameter int DEPTH_P = 256,
	parameter int WIDTH_P = 32
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH_P)-1:0] waddr,
	input  wire logic [WIDTH_P-1:0]         wdata,
	input  wire logic [$clog2(DEPTH_P)-1:0] raddr,
	output logic      [WIDTH_P-1:0]         rdata
);
	logic [WIDTH_P-1:0] mem_q [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> sim/sorted_table_search_insert_remove_top_test.sv
// Self-checking testbench for the sorted key table: directed and random find, insert and remove.
`default_nettype none
module sorted_table_search_insert_remove_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import stsir_pkg::*;

	localparam int PERIOD = 10;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int SETTLE_CYCLES = 600;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] position;
		logic [CNT_W-1:0] entries;
		logic             last;
	} reply_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [1:0]              opcode;
	logic signed [KEY_W-1:0] key;
	logic                    batch_last;
	logic                    done;
	logic [1:0]              status;
	logic [CNT_W-1:0]        position;
	logic [CNT_W-1:0]        entries;
	logic                    result_last;

	logic signed [KEY_W-1:0] table_keys[$];
	reply_t                  pending_replies[$];
	int                      mismatch_count = 0;
	int                      cycle_count = 0;
	bit                      steady = 1'b0;

	sorted_table_search_insert_remove_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.key         (key),
		.batch_last  (batch_last),
		.done        (done),
		.status      (status),
		.position    (position),
		.entries     (entries),
		.result_last (result_last)
	);

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string field, input longint got, input longint want);
		if (mismatch_count < 100)
			$display("%0t: mismatch on %s, got %0d, expected %0d", $realtime, field, got, want);
		mismatch_count++;
	endtask

	// Binary search with floor midpoint, as the block runs it.
	function automatic bit search_key(input logic signed [KEY_W-1:0] k, output int hit);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = table_keys.size() - 1;
		hit = 0;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (k == table_keys[mid]) begin
				hit = mid;
				return 1'b1;
			end
			if (k < table_keys[mid])
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		return 1'b0;
	endfunction

	function automatic reply_t predict_reply(input logic [1:0] op,
			input logic signed [KEY_W-1:0] k, input logic last);
		reply_t r;
		int idx;
		r.status = ST_MISSING;
		r.position = '0;
		r.last = last;
		case (op)
			OP_FIND: begin
				if (search_key(k, idx)) begin
					r.status = ST_DONE;
					r.position = CNT_W'(idx);
				end
			end
			OP_INSERT: begin
				if (table_keys.size() >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					idx = 0;
					while (idx < table_keys.size() && !(k < table_keys[idx]))
						idx++;
					table_keys.insert(idx, k);
					r.status = ST_DONE;
					r.position = CNT_W'(idx);
				end
			end
			OP_REMOVE: begin
				if (search_key(k, idx)) begin
					table_keys.delete(idx);
					r.status = ST_DONE;
					r.position = CNT_W'(idx);
				end
			end
			default: ;
		endcase
		r.entries = CNT_W'(table_keys.size());
		return r;
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 45 && table_keys.size() != 0)
			return table_keys[$urandom_range(table_keys.size() - 1)];
		if (r < 70)
			return KEY_W'(int'($urandom_range(40)) - 20);
		if (r < 74)
			return (r < 72) ? KEY_MIN : KEY_MAX;
		return $urandom;
	endfunction

	task automatic issue_command(input logic [1:0] op, input logic signed [KEY_W-1:0] k,
			input logic last);
		while (!steady && $urandom_range(99) < 36) begin
			start <= 1'b0;
			@(posedge clk);
		end
		pending_replies.push_back(predict_reply(op, k, last));
		start <= 1'b1;
		opcode <= op;
		key <= k;
		batch_last <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : check_words
		reply_t want;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				want = pending_replies.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (position !== want.position)
					report_mismatch("position", position, want.position);
				if (entries !== want.entries)
					report_mismatch("entries", entries, want.entries);
				if (result_last !== want.last)
					report_mismatch("result_last", result_last, want.last);
			end
		end
	end

	task automatic test_edge_cases();
		issue_command(OP_FIND, 0, 1'b0);
		issue_command(OP_REMOVE, 5, 1'b1);
		issue_command(OP_UNUSED, -1, 1'b0);
		issue_command(OP_INSERT, KEY_MAX, 1'b0);
		issue_command(OP_INSERT, KEY_MIN, 1'b0);
		issue_command(OP_INSERT, 0, 1'b0);
		issue_command(OP_INSERT, -1, 1'b1);
		issue_command(OP_INSERT, 0, 1'b0);
		issue_command(OP_INSERT, 0, 1'b0);
		issue_command(OP_FIND, KEY_MIN, 1'b0);
		issue_command(OP_FIND, KEY_MAX, 1'b1);
		issue_command(OP_FIND, -1, 1'b0);
		issue_command(OP_FIND, 0, 1'b0);
		issue_command(OP_FIND, 12345, 1'b0);
		issue_command(OP_UNUSED, KEY_MAX, 1'b1);
		issue_command(OP_REMOVE, 0, 1'b0);
		issue_command(OP_REMOVE, KEY_MAX, 1'b0);
		issue_command(OP_REMOVE, 7, 1'b0);
		issue_command(OP_REMOVE, KEY_MIN, 1'b0);
		issue_command(OP_REMOVE, -1, 1'b1);
		issue_command(OP_REMOVE, 0, 1'b0);
		issue_command(OP_REMOVE, 0, 1'b0);
		issue_command(OP_FIND, 0, 1'b1);
	endtask

	task automatic test_random_commands(input int count);
		int r;
		logic [1:0] op;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 2)
				op = OP_UNUSED;
			else if (r < 35)
				op = OP_FIND;
			else if (r < 70 && table_keys.size() < 200)
				op = OP_INSERT;
			else
				op = OP_REMOVE;
			issue_command(op, pick_key(), $urandom_range(7) == 0);
		end
	endtask

	task automatic test_repeated_keys(input int count);
		int r;
		logic [1:0] op;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 35)
				op = OP_FIND;
			else if (r < 70)
				op = OP_INSERT;
			else
				op = OP_REMOVE;
			issue_command(op, KEY_W'(int'($urandom_range(6)) - 3), $urandom_range(7) == 0);
		end
	endtask

	task automatic test_full_table();
		logic signed [KEY_W-1:0] k;
		steady = 1'b1;
		while (table_keys.size() < DEPTH)
			issue_command(OP_INSERT, pick_key(), $urandom_range(7) == 0);
		steady = 1'b0;
		issue_command(OP_INSERT, KEY_MIN, 1'b0);
		issue_command(OP_INSERT, KEY_MAX, 1'b1);
		issue_command(OP_INSERT, pick_key(), 1'b0);
		issue_command(OP_FIND, table_keys[0], 1'b0);
		issue_command(OP_FIND, table_keys[DEPTH - 1], 1'b0);
		issue_command(OP_FIND, pick_key(), 1'b1);
		issue_command(OP_UNUSED, pick_key(), 1'b0);
		while (table_keys.size() != 0) begin
			if ($urandom_range(9) == 0)
				k = $urandom;
			else
				k = table_keys[$urandom_range(table_keys.size() - 1)];
			issue_command(OP_REMOVE, k, $urandom_range(7) == 0);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		opcode <= OP_FIND;
		key <= '0;
		batch_last <= 1'b0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_cases();
		test_random_commands(900);
		test_full_table();
		test_repeated_keys(480);
		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

>>> sorted_table_search_insert_remove_top.f
+incdir+rtl
rtl/stsir_pkg.sv
rtl/stsir_ram.sv
rtl/sorted_table_search_insert_remove_top.sv
sim/sorted_table_search_insert_remove_top_test.sv
